>>> design/rle_pkg.sv
// Shared types and constants for the run-length text expander.
package rle_pkg;

    localparam logic [7:0] DIGIT_ZERO   = 8'h30;
    localparam logic [7:0] DIGIT_NINE   = 8'h39;
    localparam logic [7:0] NEWLINE_BYTE = 8'h0a;
    localparam logic [7:0] MARKER_RESET = 8'h40;
    localparam logic [3:0] DIGIT_HIGH   = 4'h3;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_DIGIT = 3'b010,
        PH_MARK  = 3'b100
    } t_phase;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       line_end;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } t_out;

    // Emission plan for one input transfer, drained in field order.
    typedef struct packed {
        logic       dig1_v;
        logic [3:0] dig1;
        logic       plain_v;
        logic [7:0] plain;
        logic [3:0] rep_cnt;
        logic [7:0] rep_byte;
        logic       dig2_v;
        logic [3:0] dig2;
        logic       mark_v;
        logic       nl_v;
    } t_plan;

    function automatic logic plan_pending(input t_plan p);
        return p.dig1_v | p.plain_v | (p.rep_cnt != 4'd0) | p.dig2_v | p.mark_v | p.nl_v;
    endfunction

endpackage

>>> design/rle_plan.sv
// Decodes one input byte against the pending state into an emission plan.
module rle_plan (
    input  rle_pkg::t_phase i_phase,
    input  logic [3:0]      i_held,
    input  logic [7:0]      i_marker,
    input  rle_pkg::t_in    i_item,
    output rle_pkg::t_plan  o_plan,
    output rle_pkg::t_phase o_phase,
    output logic [3:0]      o_held
);

    logic is_dig;

    assign is_dig = (i_item.in_byte >= rle_pkg::DIGIT_ZERO) &&
                    (i_item.in_byte <= rle_pkg::DIGIT_NINE);

    always_comb begin
        o_plan  = '0;
        o_phase = rle_pkg::PH_IDLE;
        o_held  = 4'd0;
        case (i_phase)
            rle_pkg::PH_DIGIT: begin
                if (i_item.in_byte == i_marker) begin
                    o_phase = rle_pkg::PH_MARK;
                    o_held  = i_held;
                end else begin
                    o_plan.dig1_v = 1'b1;
                    o_plan.dig1   = i_held;
                    if (is_dig) begin
                        o_phase = rle_pkg::PH_DIGIT;
                        o_held  = i_item.in_byte[3:0];
                    end else begin
                        o_plan.plain_v = 1'b1;
                        o_plan.plain   = i_item.in_byte;
                    end
                end
            end
            rle_pkg::PH_MARK: begin
                o_plan.rep_cnt  = i_held;
                o_plan.rep_byte = i_item.in_byte;
            end
            default: begin
                if (is_dig) begin
                    o_phase = rle_pkg::PH_DIGIT;
                    o_held  = i_item.in_byte[3:0];
                end else begin
                    o_plan.plain_v = 1'b1;
                    o_plan.plain   = i_item.in_byte;
                end
            end
        endcase
        if (i_item.line_end) begin
            if (o_phase != rle_pkg::PH_IDLE) begin
                o_plan.dig2_v = 1'b1;
                o_plan.dig2   = o_held;
            end
            o_plan.mark_v = (o_phase == rle_pkg::PH_MARK);
            o_plan.nl_v   = 1'b1;
            o_phase       = rle_pkg::PH_IDLE;
            o_held        = 4'd0;
        end
    end

endmodule

>>> design/rle_emit.sv
// Sequencer that drains an emission plan one byte per cycle, while the output is not stalled, into the output register.
module rle_emit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  rle_pkg::t_plan i_plan,
    input  logic [7:0]     i_marker,
    output logic           o_busy,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output rle_pkg::t_out  o_out_data
);

    rle_pkg::t_plan r_plan, n_plan, w_step;
    logic           r_out_valid;
    rle_pkg::t_out  r_out;
    logic [7:0]     w_byte;
    logic           w_free;

    assign o_busy      = rle_pkg::plan_pending(r_plan);
    assign w_free      = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        w_step = r_plan;
        w_byte = rle_pkg::NEWLINE_BYTE;
        if (r_plan.dig1_v) begin
            w_step.dig1_v = 1'b0;
            w_byte        = {rle_pkg::DIGIT_HIGH, r_plan.dig1};
        end else if (r_plan.plain_v) begin
            w_step.plain_v = 1'b0;
            w_byte         = r_plan.plain;
        end else if (r_plan.rep_cnt != 4'd0) begin
            w_step.rep_cnt = r_plan.rep_cnt - 4'd1;
            w_byte         = r_plan.rep_byte;
        end else if (r_plan.dig2_v) begin
            w_step.dig2_v = 1'b0;
            w_byte        = {rle_pkg::DIGIT_HIGH, r_plan.dig2};
        end else if (r_plan.mark_v) begin
            w_step.mark_v = 1'b0;
            w_byte        = i_marker;
        end else begin
            w_step.nl_v = 1'b0;
        end
    end

    always_comb begin
        n_plan = r_plan;
        if (i_load) begin
            n_plan = i_plan;
        end else if (o_busy && w_free) begin
            n_plan = w_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plan      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_plan <= n_plan;
            if (o_busy && w_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_busy && w_free) begin
            r_out.out_byte    <= w_byte;
            r_out.last_of_run <= !rle_pkg::plan_pending(w_step);
        end
    end

endmodule

>>> design/rle_text_expander.sv
// Run-length text expander: a digit, the marker byte and a payload byte expand
// to that many payload copies; a line end flushes pending bytes and adds a newline.
// Each input transfer is decoded combinationally into a short emission plan, which a
// sequencer drains one output byte per cycle, while the output is not stalled,
// through the output register; the input is not ready until the plan is drained,
// so an output stall also holds the input back.
// The user must write the marker through the configuration port only while the
// block is idle; the block itself does not enforce this. It resets to '@'.
module rle_text_expander (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [7:0]    i_cfg_data,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  rle_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output rle_pkg::t_out o_out_data
);

    rle_pkg::t_phase r_phase;
    logic [3:0]      r_held;
    logic [7:0]      r_marker;
    rle_pkg::t_phase w_phase;
    logic [3:0]      w_held;
    rle_pkg::t_plan  w_plan;
    logic            w_busy;
    logic            w_accept;

    assign o_in_ready = !w_busy;
    assign w_accept   = i_in_valid && o_in_ready;

    rle_plan u_plan (
        .i_phase  (r_phase),
        .i_held   (r_held),
        .i_marker (r_marker),
        .i_item   (i_in_data),
        .o_plan   (w_plan),
        .o_phase  (w_phase),
        .o_held   (w_held)
    );

    rle_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_accept),
        .i_plan      (w_plan),
        .i_marker    (r_marker),
        .o_busy      (w_busy),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= rle_pkg::PH_IDLE;
            r_held   <= 4'd0;
            r_marker <= rle_pkg::MARKER_RESET;
        end else begin
            if (w_accept) begin
                r_phase <= w_phase;
                r_held  <= w_held;
            end
            if (i_cfg_we) begin
                r_marker <= i_cfg_data;
            end
        end
    end

endmodule
